// ===== src/lpad_pkg.sv =====
// ----------------------------------------------------------------------------
// lpad_pkg
// Shared types and constants of the length-prefixed Adler-32 deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpad_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned CFG_W           = 24;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned LENGTH_BITS_DEF = 24;

  localparam logic [WORD_W-1:0] TRAILER_BYTES = 32'd4;
  localparam logic [16:0]       ADLER_MOD     = 17'd65521;

  localparam logic [CFG_W-1:0] MIN_LENGTH_RST = 24'd4;
  localparam logic [CFG_W-1:0] MAX_LENGTH_RST = 24'd65540;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2,
    PH_CLOSED  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_OK      = 2'd1,
    KIND_BAD_LEN = 2'd2,
    KIND_BAD_SUM = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ===== src/lpad_adler.sv =====
// ----------------------------------------------------------------------------
// lpad_adler
// One Adler-32 byte step: both sums advanced modulo 65521.
// ----------------------------------------------------------------------------
`default_nettype none

module lpad_adler (
  input  wire logic [15:0] low_i,
  input  wire logic [15:0] high_i,
  input  wire logic [7:0]  byte_i,
  output logic      [15:0] low_o,
  output logic      [15:0] high_o
);

  logic [16:0] low_sum;
  logic [16:0] low_mod;
  logic [16:0] high_sum;
  logic [16:0] high_mod;

  // both operands stay below the modulus, so one subtract suffices
  always_comb begin
    low_sum  = {1'b0, low_i} + {9'd0, byte_i};
    low_mod  = (low_sum >= lpad_pkg::ADLER_MOD) ? low_sum - lpad_pkg::ADLER_MOD : low_sum;
    high_sum = {1'b0, high_i} + low_mod;
    high_mod = (high_sum >= lpad_pkg::ADLER_MOD) ? high_sum - lpad_pkg::ADLER_MOD
                                                 : high_sum;
    low_o    = low_mod[15:0];
    high_o   = high_mod[15:0];
  end

endmodule

`default_nettype wire

// ===== src/lpad_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpad_ctrl
// Frame parser: header length check, payload pass-through, checksum verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module lpad_ctrl #(
  parameter int unsigned LENGTH_BITS = lpad_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [7:0]                 byte_i,
  input  wire logic [lpad_pkg::CFG_W-1:0] min_length_i,
  input  wire logic [lpad_pkg::CFG_W-1:0] max_length_i,
  output logic                            res_valid_o,
  output lpad_pkg::result_t               res_o
);

  localparam int unsigned WW = lpad_pkg::WORD_W;

  lpad_pkg::phase_e       phase_q, phase_d;
  logic [1:0]             cnt_q, cnt_d;
  logic [LENGTH_BITS-1:0] remain_q, remain_d;
  logic [WW-1:0]          word_q, word_d;
  logic [15:0]            low_q, low_d;
  logic [15:0]            high_q, high_d;
  logic [15:0]            low_step;
  logic [15:0]            high_step;
  logic [WW-1:0]          shifted;
  logic [WW-1:0]          min_ext;
  logic [WW-1:0]          max_ext;
  logic                   len_bad;

  lpad_adler u_adler (
    .low_i  (low_q),
    .high_i (high_q),
    .byte_i (byte_i),
    .low_o  (low_step),
    .high_o (high_step)
  );

  assign shifted = {word_q[WW-9:0], byte_i};
  assign min_ext = {{(WW-lpad_pkg::CFG_W){1'b0}}, min_length_i};
  assign max_ext = {{(WW-lpad_pkg::CFG_W){1'b0}}, max_length_i};
  assign len_bad = (shifted < lpad_pkg::TRAILER_BYTES) || (shifted < min_ext) ||
                   (shifted > max_ext) || ((shifted >> LENGTH_BITS) != '0);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    remain_d    = remain_q;
    word_d      = word_q;
    low_d       = low_q;
    high_d      = high_q;
    res_valid_o = 1'b0;
    res_o.kind  = lpad_pkg::KIND_DATA;
    res_o.data  = byte_i;
    res_o.last  = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        lpad_pkg::PH_HEADER: begin
          word_d = shifted;
          cnt_d  = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            if (len_bad) begin
              phase_d     = lpad_pkg::PH_CLOSED;
              res_valid_o = 1'b1;
              res_o.kind  = lpad_pkg::KIND_BAD_LEN;
              res_o.data  = 8'd0;
              res_o.last  = 1'b1;
            end else begin
              remain_d = shifted[LENGTH_BITS-1:0] -
                         lpad_pkg::TRAILER_BYTES[LENGTH_BITS-1:0];
              phase_d  = (shifted == lpad_pkg::TRAILER_BYTES) ? lpad_pkg::PH_CHECK
                                                              : lpad_pkg::PH_PAYLOAD;
            end
          end
        end
        lpad_pkg::PH_PAYLOAD: begin
          low_d       = low_step;
          high_d      = high_step;
          res_valid_o = 1'b1;
          if (remain_q == LENGTH_BITS'(1)) begin
            phase_d = lpad_pkg::PH_CHECK;
          end else begin
            remain_d = remain_q - LENGTH_BITS'(1);
          end
        end
        lpad_pkg::PH_CHECK: begin
          word_d = shifted;
          cnt_d  = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            res_valid_o = 1'b1;
            res_o.data  = 8'd0;
            res_o.last  = 1'b1;
            if (shifted == {high_q, low_q}) begin
              phase_d    = lpad_pkg::PH_HEADER;
              res_o.kind = lpad_pkg::KIND_OK;
            end else begin
              phase_d    = lpad_pkg::PH_CLOSED;
              res_o.kind = lpad_pkg::KIND_BAD_SUM;
            end
            // restart the sums for the next frame
            low_d  = 16'd1;
            high_d = 16'd0;
          end
        end
        lpad_pkg::PH_CLOSED: begin
          // drop everything until reset
        end
        default: begin
          phase_d = lpad_pkg::PH_CLOSED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lpad_pkg::PH_HEADER;
      cnt_q   <= 2'd0;
      low_q   <= 16'd1;
      high_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remain_q <= remain_d;
    word_q   <= word_d;
  end

endmodule

`default_nettype wire

// ===== src/lpad_out_buf.sv =====
// ----------------------------------------------------------------------------
// lpad_out_buf
// Result register towards the output stream, with a skid stage behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpad_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lpad_pkg::result_t push_data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              take_ready_i,
  output lpad_pkg::result_t      data_o
);

  logic              out_v_q, out_v_d;
  logic              skid_v_q, skid_v_d;
  lpad_pkg::result_t out_q, out_d;
  lpad_pkg::result_t skid_q, skid_d;
  logic              take;

  assign ready_o = !skid_v_q;
  assign valid_o = out_v_q;
  assign data_o  = out_q;
  assign take    = out_v_q && take_ready_i;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (take) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else if (push_i) begin
        out_d = push_data_i;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_v_q) begin
        out_d   = push_data_i;
        out_v_d = 1'b1;
      end else begin
        // hold the new item behind the stalled one
        skid_d   = push_data_i;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

// ===== src/length_prefix_adler_deframer.sv =====
// Adler step and length check are combinational; each result is then registered.
// Throughput: one byte per cycle while s_axis_tready is high.
// s_axis_tready drops only while two results wait, i.e. after a stalled output.
// Reset (rst_ni, asynchronous, active low): header phase, sums 1/0, output empty,
// min_length 4, max_length 65540. A bad frame closes the block until reset.
// ----------------------------------------------------------------------------
// length_prefix_adler_deframer
// Byte-stream deframer for length-prefixed frames with an Adler-32 trailer.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefix_adler_deframer #(
  parameter int unsigned LENGTH_BITS = lpad_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]                          m_axis_tuser,   // [1:0] out_kind
  output logic                                m_axis_tlast,   // frame_end
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lpad_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [lpad_pkg::CFG_W-1:0]     cfg_data_i
);

  logic [lpad_pkg::CFG_W-1:0] min_length_q;
  logic [lpad_pkg::CFG_W-1:0] max_length_q;
  logic                       accept;
  logic                       res_valid;
  lpad_pkg::result_t          res;
  lpad_pkg::result_t          out_res;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && s_axis_tready;

  // unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= lpad_pkg::MIN_LENGTH_RST;
      max_length_q <= lpad_pkg::MAX_LENGTH_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == lpad_pkg::REG_MIN_LENGTH) begin
        min_length_q <= cfg_data_i;
      end
      if (cfg_index_i == lpad_pkg::REG_MAX_LENGTH) begin
        max_length_q <= cfg_data_i;
      end
    end
  end

  lpad_ctrl #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_i       (s_axis_tdata),
    .min_length_i (min_length_q),
    .max_length_i (max_length_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  lpad_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (res_valid),
    .push_data_i  (res),
    .ready_o      (s_axis_tready),
    .valid_o      (m_axis_tvalid),
    .take_ready_i (m_axis_tready),
    .data_o       (out_res)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== src/lpad_checker.sv =====
// ----------------------------------------------------------------------------
// lpad_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpad_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // input back-pressure only while a result is waiting
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  a_verdict_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser != lpad_pkg::KIND_DATA &&
    m_axis_tdata == 8'd0)
    else $error("verdict with payload kind or data");

  a_payload_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == lpad_pkg::KIND_DATA)
    else $error("payload item with verdict kind");

endmodule

bind length_prefix_adler_deframer lpad_checker u_lpad_checker (.*);

`default_nettype wire
